@@ rtl/spq_pkg.sv @@
package spq_pkg;

  // Table geometry.
  localparam int TableEntries = 16;
  localparam int AddrW        = $clog2(TableEntries);
  localparam int SubSteps     = 5;

  // 0.5 / 5 in Q16, used to split one table interval into sub-steps.
  localparam logic signed [13:0] HalfOverSubQ16 = 14'sd6554;

  // Request codes.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuant = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [3:0]              table_slot;
    logic signed [15:0]      table_level;
    logic signed [15:0]      pred_first;
    logic signed [15:0]      pred_second;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0]      quant_difference;
    logic signed [15:0]      quant_second;
    logic [4:0]              joint_index;
    logic [1:0]              remainder_first;
    logic [2:0]              substep_first;
    logic [1:0]              remainder_second;
    logic [2:0]              substep_second;
  } out_item_t;

  // Saturate a candidate level to the 16-bit signed range.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/spq_in_if.sv @@
interface spq_in_if;
  logic               valid;
  logic               ready;
  spq_pkg::in_item_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/spq_out_if.sv @@
interface spq_out_if;
  logic               valid;
  logic               ready;
  spq_pkg::out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/stereo_predictor_quantizer.sv @@
// Stereo predictor quantizer.
// Input channel in_i carries two kinds of transaction. A load transaction
// (req_type = 0) writes table_level into entry table_slot of the level table;
// it produces no result and completes in the cycle it is accepted. A quantize
// transaction (req_type = 1) searches the table for both predictors and
// produces exactly one result transaction on out_o.
// The level table sits in a synchronous memory with a registered read port.
// Each predictor is searched one candidate level per cycle: entering an
// interval first takes the step multiply, then the first level, after which
// each sub-level is compared in turn, and the search ends early when the
// error stops decreasing. Both predictors are searched in turn, sharing
// the memory read port and the single compare unit. Input is accepted
// only while no search is running.
// After reset the block is idle and ready; the table contents are undefined
// until loaded. A finished result waits in the output register until taken,
// while a new transaction can already be accepted. If a second result is
// ready while the first still waits, the search holds until the output
// register frees up.
module stereo_predictor_quantizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  spq_in_if.sink          in_i,
  spq_out_if.source       out_o
);

  localparam logic [spq_pkg::AddrW-1:0] LastInterval =
    spq_pkg::AddrW'(spq_pkg::TableEntries - 2);
  localparam logic [2:0] SubLast = 3'(spq_pkg::SubSteps - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_LVL,
    ST_SEARCH,
    ST_FIN
  } state_e;

  // Level table memory.
  logic signed [15:0]           mem [spq_pkg::TableEntries];
  logic                         mem_we;
  logic [spq_pkg::AddrW-1:0]    mem_raddr;
  logic signed [15:0]           rdata_q;

  state_e                       state_q, state_d;
  logic                         sel_q, sel_d;
  logic signed [15:0]           pfirst_q, pfirst_d;
  logic signed [15:0]           psecond_q, psecond_d;
  logic signed [15:0]           low_q, low_d;
  logic signed [13:0]           step_q, step_d;
  logic signed [17:0]           lvl_q, lvl_d;
  logic [spq_pkg::AddrW-1:0]    ival_q, ival_d;
  logic [2:0]                   coarse_q, coarse_d;
  logic [1:0]                   rem_q, rem_d;
  logic [2:0]                   sub_q, sub_d;
  logic                         best_vld_q, best_vld_d;
  logic [18:0]                  best_err_q, best_err_d;
  logic signed [17:0]           best_lvl_q, best_lvl_d;
  logic [2:0]                   best_coarse_q, best_coarse_d;
  logic [1:0]                   best_rem_q, best_rem_d;
  logic [2:0]                   best_sub_q, best_sub_d;
  logic signed [15:0]           q0_q, q0_d;
  logic [2:0]                   k0_q, k0_d;
  logic [1:0]                   r0_q, r0_d;
  logic [2:0]                   j0_q, j0_d;
  logic                         out_valid_q, out_valid_d;
  spq_pkg::out_item_t           out_q, out_d;

  logic                         in_acc;
  logic signed [16:0]           diff;
  logic signed [30:0]           prod;
  logic signed [15:0]           pred_cur;
  logic signed [18:0]           err;
  logic [18:0]                  err_abs;
  logic                         better;
  logic signed [15:0]           q1;
  logic signed [30:0]           HalfOverSubQ16Ext;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign mem_we     = in_acc && (in_i.data.req_type == spq_pkg::ReqLoad) &&
                      (int'(in_i.data.table_slot) < spq_pkg::TableEntries);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Writes happen only while idle; the read port reads in every cycle, from
  // entry 0 while idle, so a write to entry 0 can meet a read of it.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_i.data.table_slot[spq_pkg::AddrW-1:0]] <= in_i.data.table_level;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign HalfOverSubQ16Ext = 31'(spq_pkg::HalfOverSubQ16);

  // Datapath of the search: step multiply, error and compare.
  assign diff     = {rdata_q[15], rdata_q} - {low_q[15], low_q};
  assign prod     = diff * HalfOverSubQ16Ext;
  assign pred_cur = sel_q ? psecond_q : pfirst_q;
  assign err      = {{3{pred_cur[15]}}, pred_cur} - {lvl_q[17], lvl_q};
  assign err_abs  = err[18] ? 19'(-err) : 19'(err);
  assign better   = !best_vld_q || (err_abs < best_err_q);
  assign q1       = spq_pkg::sat16(best_lvl_q);

  always_comb begin
    state_d       = state_q;
    sel_d         = sel_q;
    pfirst_d      = pfirst_q;
    psecond_d     = psecond_q;
    low_d         = low_q;
    step_d        = step_q;
    lvl_d         = lvl_q;
    ival_d        = ival_q;
    coarse_d      = coarse_q;
    rem_d         = rem_q;
    sub_d         = sub_q;
    best_vld_d    = best_vld_q;
    best_err_d    = best_err_q;
    best_lvl_d    = best_lvl_q;
    best_coarse_d = best_coarse_q;
    best_rem_d    = best_rem_q;
    best_sub_d    = best_sub_q;
    q0_d          = q0_q;
    k0_d          = k0_q;
    r0_d          = r0_q;
    j0_d          = j0_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    mem_raddr     = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.data.req_type == spq_pkg::ReqQuant)) begin
          pfirst_d  = in_i.data.pred_first;
          psecond_d = in_i.data.pred_second;
          sel_d     = 1'b0;
          state_d   = ST_RD0;
        end
      end
      ST_RD0: begin
        // Entry 0 arrives; fetch entry 1 and clear the search state.
        low_d      = rdata_q;
        mem_raddr  = spq_pkg::AddrW'(1);
        ival_d     = '0;
        coarse_d   = '0;
        rem_d      = '0;
        best_vld_d = 1'b0;
        state_d    = ST_RD1;
      end
      ST_RD1: begin
        // The read data register keeps the upper entry of the interval.
        mem_raddr = ival_q + spq_pkg::AddrW'(1);
        step_d    = prod[29:16];
        sub_d     = '0;
        state_d   = ST_LVL;
      end
      ST_LVL: begin
        mem_raddr = ival_q + spq_pkg::AddrW'(1);
        lvl_d     = {{2{low_q[15]}}, low_q} + {{4{step_q[13]}}, step_q};
        state_d   = ST_SEARCH;
      end
      ST_SEARCH: begin
        mem_raddr = ival_q + spq_pkg::AddrW'(1);
        if (better) begin
          best_vld_d    = 1'b1;
          best_err_d    = err_abs;
          best_lvl_d    = lvl_q;
          best_coarse_d = coarse_q;
          best_rem_d    = rem_q;
          best_sub_d    = sub_q;
          if (sub_q == SubLast) begin
            if (ival_q == LastInterval) begin
              state_d = ST_FIN;
            end else begin
              // Upper entry of this interval is the lower one of the next.
              low_d     = rdata_q;
              mem_raddr = ival_q + spq_pkg::AddrW'(2);
              ival_d    = ival_q + spq_pkg::AddrW'(1);
              if (rem_q == 2'd2) begin
                rem_d    = '0;
                coarse_d = coarse_q + 3'd1;
              end else begin
                rem_d = rem_q + 2'd1;
              end
              state_d = ST_RD1;
            end
          end else begin
            sub_d = sub_q + 3'd1;
            lvl_d = lvl_q + {{3{step_q[13]}}, step_q, 1'b0};
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sel_q) begin
          q0_d    = spq_pkg::sat16(best_lvl_q);
          k0_d    = best_coarse_q;
          r0_d    = best_rem_q;
          j0_d    = best_sub_q;
          sel_d   = 1'b1;
          state_d = ST_RD0;
        end else if (!out_valid_q || out_o.ready) begin
          out_d.quant_difference = {q0_q[15], q0_q} - {q1[15], q1};
          out_d.quant_second     = q1;
          out_d.joint_index      = 5'({k0_q, 2'b00}) + 5'(k0_q) + 5'(best_coarse_q);
          out_d.remainder_first  = r0_q;
          out_d.substep_first    = j0_q;
          out_d.remainder_second = best_rem_q;
          out_d.substep_second   = best_sub_q;
          out_valid_d            = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= 1'b0;
      best_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      best_vld_q  <= best_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pfirst_q      <= pfirst_d;
    psecond_q     <= psecond_d;
    low_q         <= low_d;
    step_q        <= step_d;
    lvl_q         <= lvl_d;
    ival_q        <= ival_d;
    coarse_q      <= coarse_d;
    rem_q         <= rem_d;
    sub_q         <= sub_d;
    best_err_q    <= best_err_d;
    best_lvl_q    <= best_lvl_d;
    best_coarse_q <= best_coarse_d;
    best_rem_q    <= best_rem_d;
    best_sub_q    <= best_sub_d;
    q0_q          <= q0_d;
    k0_q          <= k0_d;
    r0_q          <= r0_d;
    j0_q          <= j0_d;
    out_q         <= out_d;
  end

endmodule
